/* rtl/gtsi_pkg.sv */
// Shared types and constants of the trilinear slowness interpolator.
package gtsi_pkg;

  // Word widths of the fixed-point data.
  localparam int DATA_W    = 32;
  localparam int CELL_W    = 5;
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = DATA_W + 1;
  localparam int LOC_SHIFT = QUO_W - FRAC_W;
  localparam int PROD_W    = 50;
  localparam int CFG_IDX_W = 3;
  localparam int CORNERS   = 8;
  localparam int BANK_W    = 3;

  // Pipeline latencies of the sub-units.
  localparam int DIV_LAT   = QUO_W;
  localparam int RECIP_LAT = DIV_LAT + 1;
  localparam int LOC_LAT   = DIV_LAT + 2;
  localparam int BLEND_LAT = 2;

  localparam logic [DATA_W-1:0]        SPACING_RESET = 32'h0001_0000;
  localparam logic signed [PROD_W-1:0] ROUND_HALF    = 50'sd32768;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_Z  = 3'd0,
    CFG_ORIGIN_X  = 3'd1,
    CFG_ORIGIN_Y  = 3'd2,
    CFG_SPACING_Z = 3'd3,
    CFG_SPACING_X = 3'd4,
    CFG_SPACING_Y = 3'd5
  } cfg_reg_t;

  // Input word operations.
  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  // Eight corner slownesses, index bits are {depth, x, y} offsets.
  typedef logic [CORNERS-1:0][DATA_W-1:0] corner_set_t;

endpackage

/* rtl/grid_trilinear_slowness_interp.sv */
// Top level of the trilinear slowness interpolator.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | func, cell indexes, velocity, point
//  out_    | output    | out_valid/out_stall| interp_velocity
//  cfg_    | input     | cfg_valid/cfg_ready| register index and data
//
// One word is taken every cycle while in_stall is low.
// The latency is set by two 33-stage pipelined dividers: the cell locator
// (sharing its depth with the write reciprocal) and the output reciprocal.
// Reset clears valid bits, zeroes the origins and sets the spacings to 1.0; grid contents stay undefined.
// An output register and one skid register follow the pipeline; in_stall
// rises only when the skid register holds a word, and then all stages hold.
module grid_trilinear_slowness_interp import gtsi_pkg::*; #(
  parameter int GRID_DEPTH_CELLS = 32,
  parameter int GRID_X_CELLS     = 32,
  parameter int GRID_Y_CELLS     = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic [CELL_W-1:0]        in_cell_z,
  input  logic [CELL_W-1:0]        in_cell_x,
  input  logic [CELL_W-1:0]        in_cell_y,
  input  logic [DATA_W-1:0]        in_sample_velocity,
  input  logic signed [DATA_W-1:0] in_point_x,
  input  logic signed [DATA_W-1:0] in_point_y,
  input  logic signed [DATA_W-1:0] in_point_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DATA_W-1:0]        out_interp_velocity,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  localparam int ZW       = $clog2(GRID_DEPTH_CELLS);
  localparam int XW       = $clog2(GRID_X_CELLS);
  localparam int YW       = $clog2(GRID_Y_CELLS);
  localparam int TAIL_LAT = 3 * BLEND_LAT + RECIP_LAT;

  typedef struct packed {
    logic              qry;
    logic              wr;
    logic [CELL_W-1:0] cz;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
  } sb_t;

  logic en;

  logic signed [DATA_W-1:0] origin_z_r;
  logic signed [DATA_W-1:0] origin_x_r;
  logic signed [DATA_W-1:0] origin_y_r;
  logic [DATA_W-1:0]        spacing_z_r;
  logic [DATA_W-1:0]        spacing_x_r;
  logic [DATA_W-1:0]        spacing_y_r;

  logic                     s0_vld_r;
  func_t                    s0_func_r;
  logic [CELL_W-1:0]        s0_cz_r;
  logic [CELL_W-1:0]        s0_cx_r;
  logic [CELL_W-1:0]        s0_cy_r;
  logic [DATA_W-1:0]        s0_vel_r;
  logic signed [DATA_W-1:0] s0_px_r;
  logic signed [DATA_W-1:0] s0_py_r;
  logic signed [DATA_W-1:0] s0_pz_r;
  sb_t                      s0_sb;

  logic [DATA_W-1:0] w1_vel_r;
  logic [DATA_W-1:0] wr_slowness;
  sb_t               sb_r [LOC_LAT];
  sb_t               sb_d;

  logic [ZW-1:0]     loc_iz;
  logic [XW-1:0]     loc_ix;
  logic [YW-1:0]     loc_iy;
  logic [FRAC_W-1:0] loc_wz;
  logic [FRAC_W-1:0] loc_wx;
  logic [FRAC_W-1:0] loc_wy;

  corner_set_t       corner;
  logic              m_vld_r;
  logic [FRAC_W-1:0] m_wx_r;
  logic [FRAC_W-1:0] m_wy_r;
  logic [FRAC_W-1:0] m_wz_r;

  corner_set_t       c_corner_r;
  logic              c_vld_r;
  logic [FRAC_W-1:0] c_wx_r;
  logic [FRAC_W-1:0] c_wy_r;
  logic [FRAC_W-1:0] c_wz_r;
  logic [FRAC_W-1:0] wy_dly_r [BLEND_LAT];
  logic [FRAC_W-1:0] wz_dly_r [2 * BLEND_LAT];

  logic [DATA_W-1:0] xres [4];
  logic [DATA_W-1:0] yres [2];
  logic [DATA_W-1:0] zres;
  logic [DATA_W-1:0] res_vel;
  logic              qv_r [TAIL_LAT];
  logic              res_vld;

  logic              out_vld_r;
  logic [DATA_W-1:0] out_data_r;
  logic              skid_vld_r;
  logic [DATA_W-1:0] skid_data_r;
  logic              take;
  logic              arrive;

  // The whole pipeline moves unless the skid register is occupied.
  assign en        = !skid_vld_r;
  assign in_stall  = skid_vld_r;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_z_r  <= '0;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      spacing_z_r <= SPACING_RESET;
      spacing_x_r <= SPACING_RESET;
      spacing_y_r <= SPACING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_Z:  origin_z_r  <= cfg_data;
        CFG_ORIGIN_X:  origin_x_r  <= cfg_data;
        CFG_ORIGIN_Y:  origin_y_r  <= cfg_data;
        CFG_SPACING_Z: spacing_z_r <= cfg_data;
        CFG_SPACING_X: spacing_x_r <= cfg_data;
        CFG_SPACING_Y: spacing_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_func_r <= func_t'(in_func);
      s0_cz_r   <= in_cell_z;
      s0_cx_r   <= in_cell_x;
      s0_cy_r   <= in_cell_y;
      s0_vel_r  <= in_sample_velocity;
      s0_px_r   <= in_point_x;
      s0_py_r   <= in_point_y;
      s0_pz_r   <= in_point_z;
      w1_vel_r  <= s0_vel_r;
    end
  end

  // Writes outside the grid are dropped here.
  always_comb begin
    s0_sb.qry = s0_vld_r && (s0_func_r == FUNC_QUERY);
    s0_sb.wr  = s0_vld_r && (s0_func_r == FUNC_WRITE)
                && (int'(s0_cz_r) < GRID_DEPTH_CELLS)
                && (int'(s0_cx_r) < GRID_X_CELLS)
                && (int'(s0_cy_r) < GRID_Y_CELLS);
    s0_sb.cz  = s0_cz_r;
    s0_sb.cx  = s0_cx_r;
    s0_sb.cy  = s0_cy_r;
  end

  // Control words travel alongside the locators and the write reciprocal.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LOC_LAT; k++) begin
        sb_r[k] <= '0;
      end
    end else if (en) begin
      sb_r[0] <= s0_sb;
      for (int k = 1; k < LOC_LAT; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  assign sb_d = sb_r[LOC_LAT-1];

  // Written velocity becomes slowness.
  gtsi_recip u_recip_wr (
    .clk   (clk),
    .en    (en),
    .raw   (w1_vel_r),
    .recip (wr_slowness)
  );

  gtsi_locate #(.NCELL(GRID_DEPTH_CELLS)) u_loc_z (
    .clk     (clk),
    .en      (en),
    .point   (s0_pz_r),
    .origin  (origin_z_r),
    .spacing (spacing_z_r),
    .idx     (loc_iz),
    .weight  (loc_wz)
  );

  gtsi_locate #(.NCELL(GRID_X_CELLS)) u_loc_x (
    .clk     (clk),
    .en      (en),
    .point   (s0_px_r),
    .origin  (origin_x_r),
    .spacing (spacing_x_r),
    .idx     (loc_ix),
    .weight  (loc_wx)
  );

  gtsi_locate #(.NCELL(GRID_Y_CELLS)) u_loc_y (
    .clk     (clk),
    .en      (en),
    .point   (s0_py_r),
    .origin  (origin_y_r),
    .spacing (spacing_y_r),
    .idx     (loc_iy),
    .weight  (loc_wy)
  );

  // Writes and corner reads reach the grid at the same stage, in order.
  gtsi_grid #(
    .NZ (GRID_DEPTH_CELLS),
    .NX (GRID_X_CELLS),
    .NY (GRID_Y_CELLS)
  ) u_grid (
    .clk     (clk),
    .en      (en),
    .wr_en   (sb_d.wr),
    .wr_z    (ZW'(sb_d.cz)),
    .wr_x    (XW'(sb_d.cx)),
    .wr_y    (YW'(sb_d.cy)),
    .wr_data (wr_slowness),
    .rd_z    (loc_iz),
    .rd_x    (loc_ix),
    .rd_y    (loc_iy),
    .corner  (corner)
  );

  // Grid read stage and corner register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= sb_d.qry;
      c_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_wx_r      <= loc_wx;
      m_wy_r      <= loc_wy;
      m_wz_r      <= loc_wz;
      c_corner_r  <= corner;
      c_wx_r      <= m_wx_r;
      c_wy_r      <= m_wy_r;
      c_wz_r      <= m_wz_r;
      wy_dly_r[0] <= c_wy_r;
      wz_dly_r[0] <= c_wz_r;
      for (int k = 1; k < BLEND_LAT; k++) begin
        wy_dly_r[k] <= wy_dly_r[k-1];
      end
      for (int k = 1; k < 2 * BLEND_LAT; k++) begin
        wz_dly_r[k] <= wz_dly_r[k-1];
      end
    end
  end

  // Blend along x: lane index is {depth offset, y offset}.
  for (genvar j = 0; j < 4; j++) begin : g_bx
    gtsi_blend u_bx (
      .clk (clk),
      .en  (en),
      .a   (c_corner_r[{1'(j >> 1), 1'b0, 1'(j & 1)}]),
      .b   (c_corner_r[{1'(j >> 1), 1'b1, 1'(j & 1)}]),
      .w   (c_wx_r),
      .s   (xres[j])
    );
  end

  // Blend along y, then along depth.
  for (genvar j = 0; j < 2; j++) begin : g_by
    gtsi_blend u_by (
      .clk (clk),
      .en  (en),
      .a   (xres[2*j]),
      .b   (xres[2*j+1]),
      .w   (wy_dly_r[BLEND_LAT-1]),
      .s   (yres[j])
    );
  end

  gtsi_blend u_bz (
    .clk (clk),
    .en  (en),
    .a   (yres[0]),
    .b   (yres[1]),
    .w   (wz_dly_r[2*BLEND_LAT-1]),
    .s   (zres)
  );

  // Blended slowness back to velocity.
  gtsi_recip u_recip_out (
    .clk   (clk),
    .en    (en),
    .raw   (zres),
    .recip (res_vel)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAIL_LAT; k++) begin
        qv_r[k] <= 1'b0;
      end
    end else if (en) begin
      qv_r[0] <= c_vld_r;
      for (int k = 1; k < TAIL_LAT; k++) begin
        qv_r[k] <= qv_r[k-1];
      end
    end
  end

  assign res_vld = qv_r[TAIL_LAT-1];

  // Output register with one skid word behind it.
  assign take   = out_vld_r && !out_stall;
  assign arrive = en && res_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (take) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || take) begin
      out_vld_r <= arrive;
    end else if (arrive) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_vld_r || take) begin
      out_data_r <= res_vel;
    end else begin
      skid_data_r <= res_vel;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_interp_velocity = out_data_r;

endmodule

/* rtl/gtsi_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module gtsi_div import gtsi_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] rem0,
  input  logic [QUO_W-1:0]  num,
  input  logic [DATA_W-1:0] den,
  output logic [QUO_W-1:0]  quo
);

  logic [DATA_W-1:0] rem_r [DIV_LAT];
  logic [DATA_W-1:0] den_r [DIV_LAT];
  logic [QUO_W-1:0]  num_r [DIV_LAT];
  logic [QUO_W-1:0]  quo_r [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_step
    logic [DATA_W-1:0] rem_in;
    logic [DATA_W-1:0] den_in;
    logic [QUO_W-1:0]  num_in;
    logic [QUO_W-1:0]  quo_in;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in = rem0;
      assign den_in = den;
      assign num_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // Shift in the next dividend bit and try to subtract the divisor.
    assign trial = {rem_in, num_in[QUO_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        den_r[k] <= den_in;
        num_r[k] <= {num_in[QUO_W-2:0], 1'b0};
        quo_r[k] <= {quo_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quo = quo_r[DIV_LAT-1];

endmodule

/* rtl/gtsi_recip.sv */
// Rounded Q16.16 reciprocal, 2^32 / x, saturated to the full word.
module gtsi_recip import gtsi_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] raw,
  output logic [DATA_W-1:0] recip
);

  logic [DATA_W-1:0] den_nxt;
  logic [DATA_W-1:0] den_r;
  logic [QUO_W-1:0]  num_r;
  logic [QUO_W-1:0]  quo;

  // A zero operand is taken as one LSB; both saturate the same way.
  assign den_nxt = (raw == '0) ? DATA_W'(1) : raw;

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_nxt;
      num_r <= {1'b1, DATA_W'(0)} + QUO_W'(den_nxt >> 1);
    end
  end

  gtsi_div u_div (
    .clk  (clk),
    .en   (en),
    .rem0 ('0),
    .num  (num_r),
    .den  (den_r),
    .quo  (quo)
  );

  assign recip = quo[QUO_W-1] ? '1 : quo[DATA_W-1:0];

endmodule

/* rtl/gtsi_locate.sv */
// Per-axis clamp, cell index and Q0.16 weight of a query coordinate.
module gtsi_locate import gtsi_pkg::*; #(
  parameter int NCELL = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] point,
  input  logic signed [DATA_W-1:0] origin,
  input  logic [DATA_W-1:0]        spacing,
  output logic [$clog2(NCELL)-1:0] idx,
  output logic [FRAC_W-1:0]        weight
);

  localparam int IW   = $clog2(NCELL);
  localparam int OFFW = DATA_W + IW;
  localparam int SW   = OFFW + 2;

  logic [DATA_W-1:0]        d_nxt;
  logic signed [DATA_W-1:0] p_r;
  logic signed [DATA_W-1:0] o_r;
  logic [DATA_W-1:0]        d_r;
  logic [OFFW-1:0]          span_r;

  logic signed [SW-1:0] o_ext;
  logic signed [SW-1:0] p_ext;
  logic signed [SW-1:0] hi;
  logic signed [SW-1:0] pc;
  logic signed [SW-1:0] off_full;
  logic [OFFW-1:0]      off;

  logic [DATA_W-1:0] rem0_r;
  logic [QUO_W-1:0]  num_r;
  logic [DATA_W-1:0] den_r;
  logic [QUO_W-1:0]  quo;

  // First stage: guard the spacing and form the span of the clamp range.
  assign d_nxt = (spacing == '0) ? DATA_W'(1) : spacing;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= point;
      o_r    <= origin;
      d_r    <= d_nxt;
      span_r <= OFFW'(d_nxt) * OFFW'(NCELL - 2);
    end
  end

  // Second stage: clamp the point and take its offset from the origin.
  always_comb begin
    o_ext = SW'(o_r);
    p_ext = SW'(p_r);
    hi    = o_ext + $signed({2'b00, span_r});
    pc    = p_ext;
    if (p_ext <= o_ext) begin
      pc = o_ext;
    end
    if (p_ext >= hi) begin
      pc = hi;
    end
    off_full = pc - o_ext;
    off      = off_full[OFFW-1:0];
  end

  // The offset times 2^16 over the spacing gives index and weight at once.
  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r <= DATA_W'(off >> LOC_SHIFT);
      num_r  <= {off[LOC_SHIFT-1:0], FRAC_W'(0)};
      den_r  <= d_r;
    end
  end

  gtsi_div u_div (
    .clk  (clk),
    .en   (en),
    .rem0 (rem0_r),
    .num  (num_r),
    .den  (den_r),
    .quo  (quo)
  );

  assign idx    = quo[FRAC_W +: IW];
  assign weight = quo[FRAC_W-1:0];

endmodule

/* rtl/gtsi_grid.sv */
// Slowness grid in eight parity banks, one write and eight corner reads a cycle while en is high.
module gtsi_grid import gtsi_pkg::*; #(
  parameter int NZ = 32,
  parameter int NX = 32,
  parameter int NY = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  wr_en,
  input  logic [$clog2(NZ)-1:0] wr_z,
  input  logic [$clog2(NX)-1:0] wr_x,
  input  logic [$clog2(NY)-1:0] wr_y,
  input  logic [DATA_W-1:0]     wr_data,
  input  logic [$clog2(NZ)-1:0] rd_z,
  input  logic [$clog2(NX)-1:0] rd_x,
  input  logic [$clog2(NY)-1:0] rd_y,
  output corner_set_t           corner
);

  localparam int ZW    = $clog2(NZ);
  localparam int XW    = $clog2(NX);
  localparam int YW    = $clog2(NY);
  localparam int HZW   = (ZW > 1) ? ZW - 1 : 1;
  localparam int HXW   = (XW > 1) ? XW - 1 : 1;
  localparam int HYW   = (YW > 1) ? YW - 1 : 1;
  localparam int AW    = HZW + HXW + HYW;
  localparam int DEPTH = 1 << AW;

  logic [BANK_W-1:0] wr_bank;
  logic [AW-1:0]     wr_addr;
  logic [BANK_W-1:0] par_r;
  logic [DATA_W-1:0] rd_data [CORNERS];

  // Bank is chosen by the index parities, the address by the halved indexes.
  assign wr_bank = {wr_z[0], wr_x[0], wr_y[0]};
  assign wr_addr = {HYW'(wr_y >> 1), HXW'(wr_x >> 1), HZW'(wr_z >> 1)};

  for (genvar b = 0; b < CORNERS; b++) begin : g_bank
    localparam logic PZ = 1'((b >> 2) & 1);
    localparam logic PX = 1'((b >> 1) & 1);
    localparam logic PY = 1'(b & 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_r;
    logic [ZW-1:0]     rz;
    logic [XW-1:0]     rx;
    logic [YW-1:0]     ry;
    logic [AW-1:0]     rd_addr;

    // Each bank holds exactly one of the eight corners of the cell.
    assign rz      = rd_z + ZW'(PZ ^ rd_z[0]);
    assign rx      = rd_x + XW'(PX ^ rd_x[0]);
    assign ry      = rd_y + YW'(PY ^ rd_y[0]);
    assign rd_addr = {HYW'(ry >> 1), HXW'(rx >> 1), HZW'(rz >> 1)};

    always_ff @(posedge clk) begin
      if (en && wr_en && (wr_bank == BANK_W'(b))) begin
        mem[wr_addr] <= wr_data;
      end
      if (en) begin
        rd_r <= mem[rd_addr];
      end
    end

    assign rd_data[b] = rd_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par_r <= {rd_z[0], rd_x[0], rd_y[0]};
    end
  end

  // Put the bank outputs back in corner order.
  always_comb begin
    for (int c = 0; c < CORNERS; c++) begin
      corner[c] = rd_data[BANK_W'(c) ^ par_r];
    end
  end

endmodule

/* rtl/gtsi_blend.sv */
// One linear blend a + w*(b-a) with Q0.16 weight, rounded, over two stages.
module gtsi_blend import gtsi_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  input  logic [FRAC_W-1:0] w,
  output logic [DATA_W-1:0] s
);

  logic signed [DATA_W:0]   diff;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic [DATA_W-1:0]        a_r;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] sum;
  logic [DATA_W-1:0]        s_r;

  // Multiply stage.
  assign diff     = $signed({1'b0, b}) - $signed({1'b0, a});
  assign prod_nxt = PROD_W'(diff) * PROD_W'($signed({1'b0, w}));

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      a_r    <= a;
    end
  end

  // Round, scale back and add the base value.
  assign rnd = prod_r + ROUND_HALF;
  assign sum = PROD_W'($signed({1'b0, a_r})) + (rnd >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= sum[DATA_W-1:0];
    end
  end

  assign s = s_r;

endmodule

/* tb/grid_trilinear_slowness_interp_tb.sv */
// Self-checking testbench of the trilinear slowness interpolator.
`timescale 1ns / 100ps

module grid_trilinear_slowness_interp_tb;
  import gtsi_pkg::*;

  localparam int NZ          = 32;
  localparam int NX          = 32;
  localparam int NY          = 32;
  localparam int CELL_TOTAL  = NZ * NX * NY;
  localparam int END_CELLS   = 3;
  localparam int DRAIN_WAIT  = 200;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS  = 800;
  localparam int PHASES      = 5;

  localparam logic [31:0] Q_ONE   = 32'h0001_0000;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  typedef struct {
    func_t       op;
    logic [4:0]  cz;
    logic [4:0]  cx;
    logic [4:0]  cy;
    logic [31:0] vel;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    bit          typed;
    logic [31:0] answer;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_func = FUNC_WRITE;
  logic [CELL_W-1:0]        in_cell_z = '0;
  logic [CELL_W-1:0]        in_cell_x = '0;
  logic [CELL_W-1:0]        in_cell_y = '0;
  logic [DATA_W-1:0]        in_sample_velocity = '0;
  logic signed [DATA_W-1:0] in_point_x = '0;
  logic signed [DATA_W-1:0] in_point_y = '0;
  logic signed [DATA_W-1:0] in_point_z = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DATA_W-1:0]        out_interp_velocity;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;

  // Predictor state: slowness per cell and the register copy.
  logic [31:0] slowness_grid_model [CELL_TOTAL];
  logic [31:0] org_q [3];
  logic [31:0] spc_q [3];
  logic [31:0] velocity_due [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned hold_left = 0;

  stim_row_t directed_rows [15];

  grid_trilinear_slowness_interp uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_cell_z(in_cell_z), .in_cell_x(in_cell_x), .in_cell_y(in_cell_y),
    .in_sample_velocity(in_sample_velocity),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_interp_velocity(out_interp_velocity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Rounded Q16.16 reciprocal, saturated.
  function automatic logic [31:0] recip_q16(input logic [31:0] raw);
    longint unsigned q;
    if (raw == 0) return 32'hFFFF_FFFF;
    q = ((64'd1 << 32) + (raw >> 1)) / raw;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // Clamp a coordinate into the grid, then split into cell index and Q0.16 weight.
  function automatic void find_cell(input logic [31:0] pt, input logic [31:0] org,
                                    input logic [31:0] spc, input int ncell,
                                    output int idx, output logic [31:0] wt);
    longint p;
    longint o;
    longint hi;
    longint unsigned d;
    longint unsigned off;
    longint unsigned i;
    longint unsigned r;
    p = longint'(signed'(pt));
    o = longint'(signed'(org));
    d = (spc == 0) ? 64'd1 : {32'd0, spc};
    hi = o + longint'(ncell - 2) * longint'(d);
    if (p <= o) p = o;
    if (p >= hi) p = hi;
    off = longint'(p - o);
    i = off / d;
    if (i > ncell - 2) i = ncell - 2;
    r = off - i * d;
    if (r >= d) r = d - 1;
    idx = int'(i);
    wt = 32'((r << 16) / d);
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] w);
    longint unsigned s;
    s = (64'd65536 - w) * a + longint'(w) * b + 64'd32768;
    return 32'(s >> 16);
  endfunction

  function automatic logic [31:0] slow_at(input int z, input int x, input int y);
    return slowness_grid_model[z + x * NZ + y * NZ * NX];
  endfunction

  // Cells within a few places of either end of an axis are the ones written up front.
  function automatic bit near_end(input int i, input int ncell);
    return (i < END_CELLS) || (i >= ncell - END_CELLS);
  endfunction

  // Expected velocity at a point from the predictor's grid and registers.
  function automatic logic [31:0] predict_velocity(input logic [31:0] px,
                                                   input logic [31:0] py,
                                                   input logic [31:0] pz);
    int iz, ix, iy;
    logic [31:0] wz, wx, wy, a00, a01, a10, a11;
    find_cell(pz, org_q[0], spc_q[0], NZ, iz, wz);
    find_cell(px, org_q[1], spc_q[1], NX, ix, wx);
    find_cell(py, org_q[2], spc_q[2], NY, iy, wy);
    a00 = mix(slow_at(iz, ix, iy), slow_at(iz, ix + 1, iy), wx);
    a01 = mix(slow_at(iz, ix, iy + 1), slow_at(iz, ix + 1, iy + 1), wx);
    a10 = mix(slow_at(iz + 1, ix, iy), slow_at(iz + 1, ix + 1, iy), wx);
    a11 = mix(slow_at(iz + 1, ix, iy + 1), slow_at(iz + 1, ix + 1, iy + 1), wx);
    return recip_q16(mix(mix(a00, a01, wy), mix(a10, a11, wy), wz));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch: %s got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Drive one word and wait for it to be taken, then update the predictor.
  task automatic send_word(input stim_row_t row);
    in_valid = 1'b1;
    in_func = row.op;
    in_cell_z = row.cz;
    in_cell_x = row.cx;
    in_cell_y = row.cy;
    in_sample_velocity = row.vel;
    in_point_x = row.px;
    in_point_y = row.py;
    in_point_z = row.pz;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (row.op == FUNC_WRITE) begin
      slowness_grid_model[row.cz + row.cx * NZ + row.cy * NZ * NX] =
        recip_q16((row.vel == 0) ? 32'd1 : row.vel);
    end else if (row.typed) begin
      velocity_due.push_back(row.answer);
    end else begin
      velocity_due.push_back(predict_velocity(row.px, row.py, row.pz));
    end
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!calm) begin
      if (r >= 95) n = $urandom_range(8, 40);
      else if (r >= 65) n = $urandom_range(1, 3);
    end
    if (n != 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx <= CFG_ORIGIN_Y) org_q[idx] = value;
    else spc_q[idx - CFG_SPACING_Z] = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Let all results arrive, then let any trailing grid write settle.
  task automatic drain();
    in_valid = 1'b0;
    while (velocity_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // One coordinate: mostly in a cell near an end of the axis, sometimes anywhere or
  // at an edge of the grid. A point whose cell pair reaches the unwritten middle is
  // moved to the origin.
  function automatic logic [31:0] pick_coord(input int axis, input int ncell);
    int unsigned r;
    int          k;
    int          idx;
    longint unsigned d;
    longint o;
    logic [31:0] v;
    logic [31:0] wt;
    r = $urandom_range(0, 99);
    d = (spc_q[axis] == 0) ? 64'd1 : {32'd0, spc_q[axis]};
    o = longint'(signed'(org_q[axis]));
    k = $urandom_range(0, 3);
    if (k >= 2) k = ncell - 5 + k;
    if (r < 70) begin
      v = 32'(o + longint'(k) * longint'(d) + longint'({$urandom, $urandom} % d));
    end else if (r < 85) begin
      v = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0: v = NEG_MAX;
        1: v = POS_MAX;
        2: v = org_q[axis];
        default: v = 32'(o + longint'(ncell - 2) * longint'(d));
      endcase
    end
    find_cell(v, org_q[axis], spc_q[axis], ncell, idx, wt);
    if (idx > 1 && idx < ncell - END_CELLS) v = org_q[axis];
    return v;
  endfunction

  function automatic logic [31:0] pick_velocity();
    case ($urandom_range(0, 19))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t row;
    row.op = ($urandom_range(0, 99) < 30) ? FUNC_WRITE : FUNC_QUERY;
    row.cz = CELL_W'($urandom);
    row.cx = CELL_W'($urandom);
    row.cy = CELL_W'($urandom);
    row.vel = pick_velocity();
    row.px = pick_coord(1, NX);
    row.py = pick_coord(2, NY);
    row.pz = pick_coord(0, NZ);
    row.typed = 1'b0;
    row.answer = '0;
    return row;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (velocity_due.size() == 0) begin
        $display("[%0t] mismatch: result word with nothing expected, %h",
                 $time, out_interp_velocity);
        error_count++;
      end else begin
        logic [31:0] want;
        want = velocity_due.pop_front();
        if (out_interp_velocity !== want)
          report_mismatch("interp_velocity", out_interp_velocity, want);
      end
    end
  end

  // Receiver back-pressure: random stalls, occasional long holds.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      hold_left <= $urandom_range(10, 40);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 20);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    logic [31:0] setting [6];
    for (int i = 0; i < 3; i++) begin
      org_q[i] = '0;
      spc_q[i] = SPACING_RESET;
    end

    // Corner extremes, some with answers that follow directly from the written value, the rest predicted.
    directed_rows = '{
      '{FUNC_WRITE, 5'd0, 5'd0, 5'd0, Q_ONE, 0, 0, 0, 1'b0, 0},
      '{FUNC_QUERY, 5'd0, 5'd0, 5'd0, 0, 0, 0, 0, 1'b1, Q_ONE},
      '{FUNC_QUERY, 5'd31, 5'd31, 5'd31, 0, NEG_MAX, NEG_MAX, NEG_MAX, 1'b1, Q_ONE},
      '{FUNC_WRITE, 5'd0, 5'd0, 5'd0, 32'd0, 0, 0, 0, 1'b0, 0},
      '{FUNC_QUERY, 5'd0, 5'd0, 5'd0, 0, 0, 0, 0, 1'b1, 32'd1},
      '{FUNC_WRITE, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFF, 0, 0, 0, 1'b0, 0},
      '{FUNC_QUERY, 5'd0, 5'd0, 5'd0, 0, NEG_MAX, NEG_MAX, NEG_MAX, 1'b1, 32'hFFFF_FFFF},
      '{FUNC_WRITE, 5'd30, 5'd30, 5'd30, 32'h0002_0000, 0, 0, 0, 1'b0, 0},
      '{FUNC_QUERY, 5'd0, 5'd0, 5'd0, 0, POS_MAX, POS_MAX, POS_MAX, 1'b1, 32'h0002_0000},
      '{FUNC_WRITE, 5'd31, 5'd31, 5'd31, 32'd1, 0, 0, 0, 1'b0, 0},
      '{FUNC_QUERY, 5'd0, 5'd0, 5'd0, 0, 32'h001E_8000, 32'h001E_8000, 32'h001E_8000,
        1'b0, 0},
      '{FUNC_QUERY, 5'd0, 5'd0, 5'd0, 0, 32'h0001_4000, 32'h001D_8000, 32'h001D_FFFF,
        1'b0, 0},
      '{FUNC_WRITE, 5'd15, 5'd0, 5'd31, 32'h1234_5678, 0, 0, 0, 1'b0, 0},
      '{FUNC_QUERY, 5'd0, 5'd0, 5'd0, 0, NEG_MAX, POS_MAX, 32'h0000_C000, 1'b0, 0},
      '{FUNC_QUERY, 5'd0, 5'd0, 5'd0, 0, 32'hFFFF_0000, 32'h0001_C000, 32'h0000_0001,
        1'b0, 0}
    };

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Fill the cells near both ends of every axis; queries stay on those cells.
    calm = 1'b1;
    row.op = FUNC_WRITE;
    row.typed = 1'b0;
    row.answer = '0;
    row.px = '0;
    row.py = '0;
    row.pz = '0;
    for (int y = 0; y < NY; y++)
      for (int x = 0; x < NX; x++)
        for (int z = 0; z < NZ; z++) begin
          if (near_end(z, NZ) && near_end(x, NX) && near_end(y, NY)) begin
            row.cz = CELL_W'(z);
            row.cx = CELL_W'(x);
            row.cy = CELL_W'(y);
            row.vel = pick_velocity();
            send_word(row);
          end
        end
    calm = 1'b0;

    // Directed rows at the reset register values.
    foreach (directed_rows[i]) begin
      idle_gap();
      send_word(directed_rows[i]);
    end
    drain();

    // Random words over several register settings, extremes included.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: setting = '{32'h0, 32'h0, 32'h0, Q_ONE, Q_ONE, Q_ONE};
        1: setting = '{NEG_MAX, NEG_MAX, NEG_MAX, 32'd1, 32'd1, 32'd1};
        2: setting = '{POS_MAX, POS_MAX, POS_MAX,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        3: setting = '{$urandom, $urandom, $urandom,
                       $urandom_range(1, 32'h0040_0000), $urandom_range(1, 32'h0040_0000),
                       $urandom_range(1, 32'h0040_0000)};
        default: setting = '{32'hFFF0_0000, 32'h0123_4567, 32'hFEDC_BA98,
                             32'h0000_8000, 32'h0003_0000, $urandom_range(1, 32'hFFFF)};
      endcase
      for (int r = 0; r < 6; r++) write_reg(cfg_reg_t'(r), setting[r]);
      calm = (ph == 3);
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        if (ph == 1 && n == 40) long_hold_req = 1'b1;
        if (ph == 1 && n == 120) begin
          in_valid = 1'b0;
          while (velocity_due.size() != 0) @(negedge clk);
        end
        if (!(ph == 1 && n >= 40 && n < 100)) idle_gap();
        send_word(random_row());
      end
      calm = 1'b0;
      drain();
    end

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
